// ----- rtl/gbce_pkg.sv -----
// gbce_pkg: types and constants shared by the two-stack gap buffer editor
// no dependencies; used by gbce_ctrl, gap_buffer_cursor_editor_top and tb_top
`default_nettype none

package gbce_pkg;

  localparam int unsigned Capacity = 4096;
  localparam int unsigned Window   = 10;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned LenW     = $clog2(Capacity + 1);
  localparam int unsigned WinW     = $clog2(Window + 1);
  localparam int unsigned CharW    = 8;
  localparam int unsigned AmountW  = 13;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_DELETE    = 2'd1,
    OP_CUR_LEFT  = 2'd2,
    OP_CUR_RIGHT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_MV,
    S_MV_WR,
    S_WIN_RD,
    S_WIN_OUT
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [CharW-1:0]   text_char;
    logic [AmountW-1:0] amount;
  } in_word_t;

  typedef struct packed {
    logic [CharW-1:0]   out_char;
    logic               char_valid;
    logic [AmountW-1:0] deleted_count;
    logic               dropped;
    logic               last;
  } out_word_t;

  // one port set of a character stack memory
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [CharW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/gbce_ram.sv -----
// gbce_ram: single write port, single registered read port memory
// no dependencies; holds one character stack of the editor
`default_nettype none

module gbce_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/gbce_ctrl.sv -----
// gbce_ctrl: sequencer, stack lengths and output register of the editor
// depends on gbce_pkg; drives the two stack memories through mem_req_t
`default_nettype none

module gbce_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire gbce_pkg::in_word_t            in_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output gbce_pkg::out_word_t                out_word_o,
  output gbce_pkg::mem_req_t                 left_req_o,
  output gbce_pkg::mem_req_t                 right_req_o,
  input  wire logic [gbce_pkg::CharW-1:0]    left_rdata_i,
  input  wire logic [gbce_pkg::CharW-1:0]    right_rdata_i
);

  gbce_pkg::state_e                   state_q, state_d;
  logic [gbce_pkg::LenW-1:0]          left_len_q, left_len_d;
  logic [gbce_pkg::LenW-1:0]          right_len_q, right_len_d;
  logic [gbce_pkg::AmountW-1:0]       k_q, k_d;
  logic                               dir_left_q, dir_left_d;
  logic [gbce_pkg::AddrW-1:0]         idx_q, idx_d;
  logic [gbce_pkg::WinW-1:0]          cnt_q, cnt_d;
  gbce_pkg::out_word_t                pend_q, pend_d;
  gbce_pkg::out_word_t                out_q, out_d;
  logic                               out_valid_q, out_valid_d;

  logic                               accept;
  logic                               out_free;
  logic [gbce_pkg::LenW-1:0]          left_m1, right_m1;
  logic [gbce_pkg::LenW:0]            total;
  logic [gbce_pkg::LenW-1:0]          del_n;
  logic [gbce_pkg::WinW-1:0]          win_n;
  logic                               src_empty;

  assign in_stall_o  = (state_q != gbce_pkg::S_IDLE);
  assign accept      = in_valid_i && (state_q == gbce_pkg::S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign left_m1   = left_len_q - gbce_pkg::LenW'(1);
  assign right_m1  = right_len_q - gbce_pkg::LenW'(1);
  assign total     = {1'b0, left_len_q} + {1'b0, right_len_q};
  assign del_n     = (gbce_pkg::LenW'(in_word_i.amount) < left_len_q) ?
                     gbce_pkg::LenW'(in_word_i.amount) : left_len_q;
  assign win_n     = (left_len_q < gbce_pkg::LenW'(gbce_pkg::Window)) ?
                     left_len_q[gbce_pkg::WinW-1:0] : gbce_pkg::WinW'(gbce_pkg::Window);
  assign src_empty = dir_left_q ? (left_len_q == '0) : (right_len_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbce_pkg::S_IDLE;
      left_len_q  <= '0;
      right_len_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_len_q  <= left_len_d;
      right_len_q <= right_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    dir_left_q <= dir_left_d;
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    left_len_d  = left_len_q;
    right_len_d = right_len_q;
    k_d         = k_q;
    dir_left_d  = dir_left_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    left_req_o.we     = 1'b0;
    left_req_o.waddr  = left_len_q[gbce_pkg::AddrW-1:0];
    left_req_o.wdata  = in_word_i.text_char;
    left_req_o.raddr  = (state_q == gbce_pkg::S_MV) ?
                        left_m1[gbce_pkg::AddrW-1:0] : idx_q;
    right_req_o.we    = 1'b0;
    right_req_o.waddr = right_len_q[gbce_pkg::AddrW-1:0];
    right_req_o.wdata = left_rdata_i;
    right_req_o.raddr = right_m1[gbce_pkg::AddrW-1:0];

    unique case (state_q)
      gbce_pkg::S_IDLE: begin
        if (accept) begin
          pend_d = '0;
          pend_d.last = 1'b1;
          unique case (in_word_i.op)
            gbce_pkg::OP_INSERT: begin
              if (total >= (gbce_pkg::LenW + 1)'(gbce_pkg::Capacity)) begin
                pend_d.dropped = 1'b1;
              end else begin
                left_req_o.we = 1'b1;
                left_len_d    = left_len_q + gbce_pkg::LenW'(1);
              end
              state_d = gbce_pkg::S_EMIT;
            end
            gbce_pkg::OP_DELETE: begin
              left_len_d           = left_len_q - del_n;
              pend_d.deleted_count = gbce_pkg::AmountW'(del_n);
              state_d              = gbce_pkg::S_EMIT;
            end
            gbce_pkg::OP_CUR_LEFT, gbce_pkg::OP_CUR_RIGHT: begin
              k_d        = in_word_i.amount;
              dir_left_d = (in_word_i.op == gbce_pkg::OP_CUR_LEFT);
              state_d    = gbce_pkg::S_MV;
            end
            default: ;
          endcase
        end
      end

      gbce_pkg::S_EMIT: begin
        if (out_free) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = gbce_pkg::S_IDLE;
        end
      end

      // pop one char from the source (data next cycle) or end the move
      gbce_pkg::S_MV: begin
        if ((k_q != '0) && !src_empty) begin
          k_d = k_q - gbce_pkg::AmountW'(1);
          if (dir_left_q) begin
            left_len_d = left_m1;
          end else begin
            right_len_d = right_m1;
          end
          state_d = gbce_pkg::S_MV_WR;
        end else if (left_len_q == '0) begin
          pend_d      = '0;
          pend_d.last = 1'b1;
          state_d     = gbce_pkg::S_EMIT;
        end else begin
          idx_d   = left_len_q[gbce_pkg::AddrW-1:0] - gbce_pkg::AddrW'(win_n);
          cnt_d   = win_n - gbce_pkg::WinW'(1);
          state_d = gbce_pkg::S_WIN_RD;
        end
      end

      // push the popped character onto the other stack
      gbce_pkg::S_MV_WR: begin
        if (dir_left_q) begin
          right_req_o.we = 1'b1;
          right_len_d    = right_len_q + gbce_pkg::LenW'(1);
        end else begin
          left_req_o.we    = 1'b1;
          left_req_o.wdata = right_rdata_i;
          left_len_d       = left_len_q + gbce_pkg::LenW'(1);
        end
        state_d = gbce_pkg::S_MV;
      end

      gbce_pkg::S_WIN_RD: begin
        state_d = gbce_pkg::S_WIN_OUT;
      end

      // read address holds idx_q, so the data stays put while stalled
      gbce_pkg::S_WIN_OUT: begin
        if (out_free) begin
          out_d.out_char      = left_rdata_i;
          out_d.char_valid    = 1'b1;
          out_d.deleted_count = '0;
          out_d.dropped       = 1'b0;
          out_d.last          = (cnt_q == '0);
          out_valid_d         = 1'b1;
          if (cnt_q == '0) begin
            state_d = gbce_pkg::S_IDLE;
          end else begin
            idx_d   = idx_q + gbce_pkg::AddrW'(1);
            cnt_d   = cnt_q - gbce_pkg::WinW'(1);
            state_d = gbce_pkg::S_WIN_RD;
          end
        end
      end

      default: state_d = gbce_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/gap_buffer_cursor_editor_top.sv -----
// gap_buffer_cursor_editor_top: text buffer with cursor held as two stacks
// depends on gbce_pkg, gbce_ctrl and gbce_ram
//
//   channel | handshake              | word type
//   --------+------------------------+---------------------
//   input   | in_valid_i / in_stall_o  | gbce_pkg::in_word_t
//   output  | out_valid_o / out_stall_i| gbce_pkg::out_word_t
//
// insert and delete: result via S_EMIT; in_stall_o holds off the next word
// a cursor move reads then writes each character moved (S_MV, S_MV_WR),
// ends the move, then reads each window character from the left stack
// memory (S_WIN_RD, S_WIN_OUT), or sends the reply if the window is empty
// reset empties both stacks at once; memory contents are left as they are
// an output stall holds the result register and the sequencer waits on it
`default_nettype none

module gap_buffer_cursor_editor_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire gbce_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output gbce_pkg::out_word_t      out_word_o
);

  gbce_pkg::mem_req_t            left_req, right_req;
  logic [gbce_pkg::CharW-1:0]    left_rdata, right_rdata;

  gbce_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_word_i     (in_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_o    (out_word_o),
    .left_req_o    (left_req),
    .right_req_o   (right_req),
    .left_rdata_i  (left_rdata),
    .right_rdata_i (right_rdata)
  );

  gbce_ram #(
    .Depth (gbce_pkg::Capacity),
    .Width (gbce_pkg::CharW)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_req.we),
    .waddr_i (left_req.waddr),
    .wdata_i (left_req.wdata),
    .raddr_i (left_req.raddr),
    .rdata_o (left_rdata)
  );

  gbce_ram #(
    .Depth (gbce_pkg::Capacity),
    .Width (gbce_pkg::CharW)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_req.we),
    .waddr_i (right_req.waddr),
    .wdata_i (right_req.wdata),
    .raddr_i (right_req.raddr),
    .rdata_o (right_rdata)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for the two-stack gap buffer cursor editor
// depends on gbce_pkg and gap_buffer_cursor_editor_top; drives edit words, checks result words
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gbce_pkg::*;

  // cycle limit for the whole run; reaching it fails the run
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned RandomEdits = 185;
  localparam logic [AmountW-1:0] MaxAmt = '1;

  // single closing word with no character, no count and no drop
  localparam out_word_t EmptyReply   = {8'h00, 1'b0, 13'd0, 1'b0, 1'b1};
  localparam out_word_t DeletedOne   = {8'h00, 1'b0, 13'd1, 1'b0, 1'b1};

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t reply;
  } edit_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_word   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;

  // shadow of the two character stacks
  logic [CharW-1:0] left_text  [Capacity];
  logic [CharW-1:0] right_text [Capacity];
  int unsigned      left_count  = 0;
  int unsigned      right_count = 0;

  out_word_t   expected_words [$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned stall_left = 0;
  bit          idling_on  = 1'b1;

  gap_buffer_cursor_editor_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stalls in bursts of random length, started only while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic note_mismatch(input string what, input out_word_t want, input out_word_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%0s) at cycle %0d", what, cycles);
      $display("  expected: char %02h valid %0d deleted %0d dropped %0d last %0d",
               want.out_char, want.char_valid, want.deleted_count, want.dropped, want.last);
      $display("  actual:   char %02h valid %0d deleted %0d dropped %0d last %0d",
               got.out_char, got.char_valid, got.deleted_count, got.dropped, got.last);
    end
  endtask

  // a word seen here with valid high and stall low is taken at the next rising edge
  always @(negedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        note_mismatch("no word expected", '0, out_word);
      end else begin
        want = expected_words.pop_front();
        if (out_word.out_char !== want.out_char || out_word.char_valid !== want.char_valid ||
            out_word.deleted_count !== want.deleted_count ||
            out_word.dropped !== want.dropped || out_word.last !== want.last) begin
          note_mismatch("field differs", want, out_word);
        end
      end
    end
  end

  task automatic expect_word(input out_word_t r);
    expected_words = {expected_words, r};
  endtask

  // applies one accepted edit to the shadow stacks and queues its words, or the typed word if typed
  task automatic apply_edit(input in_word_t w, input bit typed, input out_word_t typed_word);
    out_word_t   r;
    int unsigned steps;
    int unsigned span;
    int unsigned first;
    r = EmptyReply;
    case (w.op)
      OP_INSERT: begin
        if (left_count + right_count >= Capacity) begin
          r.dropped = 1'b1;
        end else begin
          left_text[left_count] = w.text_char;
          left_count++;
        end
        if (!typed) expect_word(r);
      end
      OP_DELETE: begin
        steps = (w.amount < left_count) ? w.amount : left_count;
        left_count -= steps;
        r.deleted_count = AmountW'(steps);
        if (!typed) expect_word(r);
      end
      default: begin
        steps = w.amount;
        if (w.op == OP_CUR_LEFT) begin
          while (steps != 0 && left_count != 0) begin
            left_count--;
            right_text[right_count] = left_text[left_count];
            right_count++;
            steps--;
          end
        end else begin
          while (steps != 0 && right_count != 0) begin
            right_count--;
            left_text[left_count] = right_text[right_count];
            left_count++;
            steps--;
          end
        end
        span  = (left_count < Window) ? left_count : Window;
        first = left_count - span;
        if (span == 0) begin
          if (!typed) expect_word(r);
        end
        for (int unsigned i = 0; i < span; i++) begin
          r.out_char   = left_text[first + i];
          r.char_valid = 1'b1;
          r.last       = (i + 1 == span);
          if (!typed) expect_word(r);
        end
      end
    endcase
    if (typed) expect_word(typed_word);
  endtask

  task automatic send_edit(input in_word_t w, input bit typed, input out_word_t typed_word);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    apply_edit(w, typed, typed_word);
  endtask

  function automatic edit_row_t edit_step(input op_e op, input logic [CharW-1:0] ch,
                                          input logic [AmountW-1:0] amt, input bit typed,
                                          input out_word_t reply);
    edit_row_t s;
    s.word.op        = op;
    s.word.text_char = ch;
    s.word.amount    = amt;
    s.typed          = typed;
    s.reply          = reply;
    return s;
  endfunction

  initial begin
    edit_row_t plan [$];
    in_word_t  w;
    int unsigned pick;

    // directed edits: empty text first, then a short line worked from both ends
    plan = {plan, edit_step(OP_CUR_LEFT,  8'h00, 13'd0,     1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_CUR_RIGHT, 8'hff, MaxAmt,    1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_DELETE,    8'h00, MaxAmt,    1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'h00, 13'd0,     1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'hff, MaxAmt,    1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'h55, 13'h0aaa,  1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'haa, 13'h1555,  1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'h41, 13'd0,     1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'h42, 13'd0,     1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'h43, 13'd0,     1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'h44, 13'd0,     1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'h45, 13'd0,     1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'h46, 13'd0,     1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'h47, 13'd0,     1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'h48, 13'd0,     1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_CUR_LEFT,  8'h00, 13'd0,     1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_CUR_LEFT,  8'h00, 13'd3,     1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_DELETE,    8'h00, 13'd1,     1'b1, DeletedOne)};
    plan = {plan, edit_step(OP_CUR_RIGHT, 8'h00, MaxAmt,    1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_CUR_LEFT,  8'h00, 13'd4096,  1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_CUR_RIGHT, 8'h00, 13'd1,     1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_CUR_RIGHT, 8'h00, 13'd2,     1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_DELETE,    8'h00, 13'd4096,  1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_CUR_RIGHT, 8'h00, MaxAmt,    1'b0, EmptyReply)};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_edit(plan[i].word, plan[i].typed, plan[i].reply);

    // random edits: inserts dominate so the text grows, counts are mostly short
    for (int n = 0; n < RandomEdits; n++) begin
      if (n == RandomEdits / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) w.op = OP_INSERT;
      else if (pick < 6) w.op = OP_DELETE;
      else if (pick < 8) w.op = OP_CUR_LEFT;
      else w.op = OP_CUR_RIGHT;
      w.text_char = CharW'($urandom_range(0, 255));
      pick = $urandom_range(0, 19);
      if (pick < 14) w.amount = AmountW'($urandom_range(0, 12));
      else if (pick < 18) w.amount = AmountW'($urandom_range(13, 200));
      else w.amount = AmountW'($urandom_range(0, MaxAmt));
      send_edit(w, 1'b0, EmptyReply);
    end

    // last part runs without idling: sweep the cursor over the whole text and edit at both ends
    idling_on = 1'b0;
    plan.delete();
    plan = {plan, edit_step(OP_CUR_LEFT,  8'h00, 13'd7,    1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_CUR_RIGHT, 8'h00, MaxAmt,   1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_CUR_LEFT,  8'h00, MaxAmt,   1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'h31, 13'd0,    1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_CUR_RIGHT, 8'h00, 13'd4096, 1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_DELETE,    8'h00, 13'd5,    1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_INSERT,    8'h5a, 13'd0,    1'b1, EmptyReply)};
    plan = {plan, edit_step(OP_DELETE,    8'h00, MaxAmt,   1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_CUR_RIGHT, 8'h00, 13'd3,    1'b0, EmptyReply)};
    plan = {plan, edit_step(OP_CUR_LEFT,  8'h00, 13'd1,    1'b0, EmptyReply)};
    foreach (plan[i]) send_edit(plan[i].word, plan[i].typed, plan[i].reply);

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
